>>> rtl/nca_pkg.sv
// Shared types and constants of the neighbor cache.
package nca_pkg;

   // Input mode codes as they arrive on the request word.
   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic [1:0] CSR_AGING_SECONDS  = 2'd0;
   localparam logic [1:0] CSR_RENEW_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_SWEEP_INTERVAL = 2'd2;
   localparam logic [1:0] CSR_ACTIVE_ENTRIES = 2'd3;

   localparam logic [15:0] AGING_RESET    = 16'd60;
   localparam logic [7:0]  RENEW_RESET    = 8'd3;
   localparam logic [7:0]  INTERVAL_RESET = 8'd5;
   localparam logic [6:0]  ACTIVE_RESET   = 7'd64;

   localparam logic [31:0] STALE_PUSH = 32'd2;

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_REMOVE,
      OP_LOOKUP,
      OP_TICK
   } nca_op_type;

   typedef enum logic [1:0] {
      E_IDLE,
      E_SCAN,
      E_SWEEP,
      E_FINISH
   } nca_state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [47:0] next_hop_mac;
      logic [1:0]  port_kind;
      logic        ip_family;
   } nca_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] found_mac;
      logic        arp_valid;
      logic [31:0] arp_target;
      logic        last;
   } nca_rsp_type;

   typedef struct packed {
      nca_op_type  op;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [47:0] mac;
      logic [1:0]  port;
      logic        family;
   } nca_cmd_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [47:0] mac;
      logic [1:0]  port;
      logic        family;
      logic [31:0] last_used;
      logic [7:0]  renews;
   } nca_entry_type;

   typedef struct packed {
      logic [15:0] aging_seconds;
      logic [7:0]  renew_limit;
      logic [7:0]  sweep_interval;
      logic [6:0]  active_entries;
   } nca_csr_type;

endpackage

>>> rtl/nca_front.sv
// Front end: accepts request words and classifies them into commands.
module nca_front import nca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  nca_req_type req_data,
   output logic        push_valid,
   output nca_cmd_type push_cmd,
   input  logic        push_ready
);

   logic        hold_vld_ff, hold_vld_in;
   nca_cmd_type hold_ff, hold_in;
   nca_cmd_type classified;
   logic        accept;

   always_comb begin
      classified.key_high = req_data.key_high;
      classified.key_low  = req_data.key_low;
      classified.mac      = req_data.next_hop_mac;
      classified.port     = req_data.port_kind;
      classified.family   = req_data.ip_family;
      unique case (req_data.mode)
         MODE_CREATE: classified.op = OP_CREATE;
         MODE_REMOVE: classified.op = OP_REMOVE;
         MODE_LOOKUP: classified.op = OP_LOOKUP;
         MODE_TICK:   classified.op = OP_TICK;
         default:     classified.op = OP_TICK;
      endcase
   end

   assign busy       = hold_vld_ff && !push_ready;
   assign accept     = start && !busy;
   assign push_valid = hold_vld_ff;
   assign push_cmd   = hold_ff;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      if (accept) begin
         hold_vld_in = 1'b1;
         hold_in     = classified;
      end else if (push_ready) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

>>> rtl/nca_queue.sv
// Two-entry command queue between the front end and the table engine.
module nca_queue import nca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  nca_cmd_type push_cmd,
   output logic        push_ready,
   output logic        pop_valid,
   output nca_cmd_type pop_cmd,
   input  logic        pop
);

   nca_cmd_type q_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_cmd    = q_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/nca_engine.sv
// Table engine: slot memory, key scan, lookup refresh and aging sweep.
module nca_engine import nca_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  nca_cmd_type q_cmd,
   output logic        q_pop,
   input  nca_csr_type csr,
   output logic        rsp_valid,
   output nca_rsp_type rsp_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = IW + 1;

   nca_entry_type mem [TABLE_DEPTH];
   nca_entry_type rd_ff;

   nca_state_type          state_ff, state_in;
   nca_cmd_type            cmd_ff, cmd_in;
   logic [CW-1:0]          iss_ff, iss_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IW-1:0]          chk_idx_ff, chk_idx_in;
   logic                   free_vld_ff, free_vld_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [31:0]            pend_tgt_ff, pend_tgt_in;
   logic [31:0]            seconds_ff, seconds_in;
   logic [7:0]             countdown_ff, countdown_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   nca_rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0] lim;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   nca_entry_type mem_wdata;
   logic          chk_hit, scan_end, sweep_end, sweep_go, renew;

   always_comb begin
      if (32'(csr.active_entries) > TABLE_DEPTH) begin
         lim = CW'(TABLE_DEPTH);
      end else begin
         lim = CW'(csr.active_entries);
      end
   end

   assign q_pop   = (state_ff == E_IDLE) && q_valid;
   assign rd_addr = iss_ff[IW-1:0];
   assign rd_en   = ((state_ff == E_SCAN) && (iss_ff < CW'(TABLE_DEPTH)))
                 || ((state_ff == E_SWEEP) && (iss_ff < lim));
   assign chk_hit = chk_vld_ff && valid_ff[chk_idx_ff]
                 && (rd_ff.key_high == cmd_ff.key_high)
                 && (rd_ff.key_low == cmd_ff.key_low);
   assign scan_end  = chk_vld_ff && (chk_idx_ff == IW'(TABLE_DEPTH - 1));
   assign sweep_end = chk_vld_ff && (({1'b0, chk_idx_ff} + CW'(1)) == lim);
   assign sweep_go  = q_pop && (q_cmd.op == OP_TICK) && (countdown_ff == 8'd0)
                   && (lim != '0);
   // The sum is taken one bit wider so that it never wraps.
   assign renew = (rd_ff.renews < csr.renew_limit)
               && (({1'b0, rd_ff.last_used} + 33'(csr.aging_seconds))
                   > {1'b0, seconds_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (q_pop && (q_cmd.op != OP_TICK)) begin
               state_in = E_SCAN;
            end else if (sweep_go) begin
               state_in = E_SWEEP;
            end
         end
         E_SCAN: begin
            if (chk_hit || scan_end) begin
               state_in = E_IDLE;
            end
         end
         E_SWEEP: begin
            if (sweep_end) begin
               state_in = E_FINISH;
            end
         end
         E_FINISH: state_in = E_IDLE;
         default:  state_in = E_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = iss_ff[IW-1:0];
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_tgt_in  = pend_tgt_ff;
      seconds_in   = seconds_ff;
      countdown_in = countdown_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      mem_we       = 1'b0;
      mem_waddr    = chk_idx_ff;
      mem_wdata    = rd_ff;

      if (rd_en) begin
         iss_in     = iss_ff + CW'(1);
         chk_vld_in = 1'b1;
      end

      unique case (state_ff)
         E_IDLE: begin
            if (q_pop) begin
               cmd_in      = q_cmd;
               iss_in      = '0;
               free_vld_in = 1'b0;
               pend_vld_in = 1'b0;
               if (q_cmd.op == OP_TICK) begin
                  seconds_in = seconds_ff + 32'd1;
                  if (countdown_ff != 8'd0) begin
                     countdown_in = countdown_ff - 8'd1;
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                  end else begin
                     countdown_in = (csr.sweep_interval == 8'd0) ? 8'd0
                                  : csr.sweep_interval - 8'd1;
                     if (lim == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.last  = 1'b1;
                     end
                  end
               end
            end
         end
         E_SCAN: begin
            if (chk_vld_ff && !valid_ff[chk_idx_ff] && ({1'b0, chk_idx_ff} < lim)
                && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (chk_hit) begin
               chk_vld_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               case (cmd_ff.op)
                  OP_CREATE: begin
                     mem_we           = 1'b1;
                     mem_wdata.mac    = cmd_ff.mac;
                     mem_wdata.renews = 8'd0;
                  end
                  OP_REMOVE: valid_in[chk_idx_ff] = 1'b0;
                  OP_LOOKUP: begin
                     rsp_in.found_mac = rd_ff.mac;
                     if (rd_ff.last_used < seconds_ff) begin
                        mem_we              = 1'b1;
                        mem_wdata.last_used = seconds_ff + STALE_PUSH;
                     end
                  end
                  default: rsp_in.status = STATUS_OK;
               endcase
            end else if (scan_end) begin
               chk_vld_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (cmd_ff.op == OP_CREATE) begin
                  if (free_vld_in) begin
                     mem_we                = 1'b1;
                     mem_waddr             = free_idx_in;
                     mem_wdata.key_high    = cmd_ff.key_high;
                     mem_wdata.key_low     = cmd_ff.key_low;
                     mem_wdata.mac         = cmd_ff.mac;
                     mem_wdata.port        = cmd_ff.port;
                     mem_wdata.family      = cmd_ff.family;
                     mem_wdata.last_used   = seconds_ff;
                     mem_wdata.renews      = 8'd0;
                     valid_in[free_idx_in] = 1'b1;
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
         end
         E_SWEEP: begin
            if (chk_vld_ff && valid_ff[chk_idx_ff]) begin
               if (renew) begin
                  if (!rd_ff.family) begin
                     mem_we           = 1'b1;
                     mem_wdata.renews = rd_ff.renews + 8'd1;
                     // The held request goes out now; this one waits to learn
                     // whether it is the final word of the sweep.
                     if (pend_vld_ff) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.arp_valid  = 1'b1;
                        rsp_in.arp_target = pend_tgt_ff;
                     end
                     pend_vld_in = 1'b1;
                     pend_tgt_in = rd_ff.key_high[63:32];
                  end
               end else begin
                  valid_in[chk_idx_ff] = 1'b0;
               end
            end
            if (sweep_end) begin
               chk_vld_in = 1'b0;
            end
         end
         E_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (pend_vld_ff) begin
               rsp_in.arp_valid  = 1'b1;
               rsp_in.arp_target = pend_tgt_ff;
            end
            pend_vld_in = 1'b0;
         end
         default: pend_vld_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         seconds_ff   <= 32'd0;
         countdown_ff <= 8'd0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         seconds_ff   <= seconds_in;
         countdown_ff <= countdown_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      pend_tgt_ff <= pend_tgt_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_finish_emits_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == E_FINISH |=> rsp_valid_ff && rsp_ff.last)
      else $error("sweep finish did not emit a final word");

   a_check_only_busy: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == E_SCAN) || (state_ff == E_SWEEP))
      else $error("compare stage active while engine idle");

   a_plain_word_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.arp_valid |-> rsp_ff.last)
      else $error("non-ARP word not marked last");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == E_IDLE && !chk_vld_ff)
      else $error("command taken while engine busy");
`endif

endmodule

>>> rtl/neighbor_cache_with_aging.sv
// Top level of the neighbor cache: control registers, front end, queue, engine.
//
//  channel  ports                                 handshake
//  request  start, busy, req_data                 taken when start && !busy
//  result   rsp_valid, rsp_data                   one-cycle strobe, no stall
//  control  csr_valid, csr_ready, csr_index/wdata written when valid && ready
//
// Create, remove and lookup scan the slot memory one read per cycle; a hit ends
// the scan and answers, a miss answers after the last slot. A tick without a
// sweep answers from the idle state; a sweep reads the first active_entries
// slots and ends with its final word from the finish state, its ARP words going
// out along the way. Reset clears all valid bits at once, so no clearing pass is
// needed. The receiver cannot stall; the front end takes a new word while the
// engine works until the two-entry queue and its holding stage are full.
module neighbor_cache_with_aging import nca_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  nca_req_type req_data,
   output logic        rsp_valid,
   output nca_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   nca_csr_type csr_ff, csr_in;
   logic        push_valid, push_ready, pop_valid, pop;
   nca_cmd_type push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_AGING_SECONDS:  csr_in.aging_seconds  = csr_wdata;
            CSR_RENEW_LIMIT:    csr_in.renew_limit    = csr_wdata[7:0];
            CSR_SWEEP_INTERVAL: csr_in.sweep_interval = csr_wdata[7:0];
            CSR_ACTIVE_ENTRIES: csr_in.active_entries = csr_wdata[6:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.aging_seconds  <= AGING_RESET;
         csr_ff.renew_limit    <= RENEW_RESET;
         csr_ff.sweep_interval <= INTERVAL_RESET;
         csr_ff.active_entries <= ACTIVE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   nca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   nca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   nca_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (pop),
      .csr       (csr_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
